@@ hdl/arsym_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// arsym_pkg
// Shared constants and types for the address range symbol table: table
// capacity, command codes, the item that moves along the cell chain and the
// entry write bus.
// ----------------------------------------------------------------------------
package arsym_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);

    localparam logic [1:0] MODE_REGISTER   = 2'd0;
    localparam logic [1:0] MODE_UNREGISTER = 2'd1;
    localparam logic [1:0] MODE_LOOKUP     = 2'd2;
    localparam logic [1:0] MODE_CLEAR      = 2'd3;

    // Item travelling down the chain, with what the cells found so far.
    typedef struct packed {
        logic             active;
        logic [1:0]       mode;
        logic [63:0]      address;
        logic [31:0]      region_size;
        logic [15:0]      symbol_id;
        logic             match_found;
        logic [IDX_W-1:0] match_idx;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        logic             best_valid;
        logic [63:0]      best_start;
        logic [31:0]      best_len;
        logic [15:0]      best_sym;
    } pkt_t;

    // Entry update broadcast to every cell.
    typedef struct packed {
        logic             set;
        logic             drop;
        logic             clear_all;
        logic [IDX_W-1:0] index;
        logic [63:0]      start;
        logic [31:0]      length;
        logic [15:0]      symbol;
    } wr_t;

endpackage
`default_nettype wire

@@ hdl/arsym_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// arsym_if
// Valid/ready channels of the address range symbol table: the command
// channel and the result channel.
// ----------------------------------------------------------------------------
interface arsym_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [63:0] address;
    logic [31:0] region_size;
    logic [15:0] symbol_id;

    modport source (output valid, output mode, output address, output region_size,
                    output symbol_id, input ready);
    modport sink   (input valid, input mode, input address, input region_size,
                    input symbol_id, output ready);
endinterface

interface arsym_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [63:0] found_start;
    logic [31:0] found_size;
    logic [15:0] found_id;
    logic        table_full;

    modport source (output valid, output hit, output found_start, output found_size,
                    output found_id, output table_full, input ready);
    modport sink   (input valid, input hit, input found_start, input found_size,
                    input found_id, input table_full, output ready);
endinterface
`default_nettype wire

@@ hdl/arsym_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// arsym_cell
// One table entry. Updates the passing item with start match, free slot and
// best lookup candidate, and registers it for the next cell.
// ----------------------------------------------------------------------------
module arsym_cell
    import arsym_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] cell_index,
    input  wire pkt_t             pkt_in,
    input  wire wr_t              wr,
    output pkt_t                  pkt_out
);

    logic        valid_reg;
    logic [63:0] start_reg;
    logic [31:0] length_reg;
    logic [15:0] symbol_reg;

    logic        active_reg;
    pkt_t        body_reg;
    pkt_t        body_next;
    logic        sel;

    assign sel = (wr.index == cell_index);

    always_comb
    begin
        body_next = pkt_in;
        if (valid_reg && start_reg == pkt_in.address && !pkt_in.match_found)
        begin
            body_next.match_found = 1'b1;
            body_next.match_idx   = cell_index;
        end
        if (!valid_reg && !pkt_in.free_found)
        begin
            body_next.free_found = 1'b1;
            body_next.free_idx   = cell_index;
        end
        // starts are unique, so a strict compare never ties
        if (valid_reg && start_reg <= pkt_in.address &&
            (!pkt_in.best_valid || start_reg > pkt_in.best_start))
        begin
            body_next.best_valid = 1'b1;
            body_next.best_start = start_reg;
            body_next.best_len   = length_reg;
            body_next.best_sym   = symbol_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= pkt_in.active;
            if (wr.clear_all)
            begin
                valid_reg <= 1'b0;
            end
            else if (wr.set && sel)
            begin
                valid_reg <= 1'b1;
            end
            else if (wr.drop && sel)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        body_reg <= body_next;
        if (wr.set && sel)
        begin
            start_reg  <= wr.start;
            length_reg <= wr.length;
            symbol_reg <= wr.symbol;
        end
    end

    always_comb
    begin
        pkt_out        = body_reg;
        pkt_out.active = active_reg;
    end

endmodule
`default_nettype wire

@@ hdl/arsym_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// arsym_ctrl
// Sequencer: injects an item into the chain, applies the table update when
// it leaves the chain, forms the result and holds it in the output register.
// ----------------------------------------------------------------------------
module arsym_ctrl
    import arsym_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    arsym_req_if.sink   req,
    arsym_rsp_if.source rsp,
    output pkt_t        inject,
    input  wire pkt_t   tail,
    output wr_t         wr
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;
    pkt_t        hold_reg;
    logic        out_valid_reg;
    logic        out_load;
    logic        hit_reg;
    logic [63:0] start_out_reg;
    logic [31:0] size_out_reg;
    logic [15:0] id_out_reg;
    logic        full_reg;
    logic        hit_now;
    logic [63:0] offset;

    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        inject             = '0;
        inject.active      = req.valid && req.ready;
        inject.mode        = req.mode;
        inject.address     = req.address;
        inject.region_size = req.region_size;
        inject.symbol_id   = req.symbol_id;
    end

    // update from the finished item; existing start wins over a free slot
    always_comb
    begin
        wr           = '0;
        wr.index     = tail.match_found ? tail.match_idx : tail.free_idx;
        wr.start     = tail.address;
        wr.length    = tail.region_size;
        wr.symbol    = tail.symbol_id;
        if (state_reg == ST_RUN && tail.active)
        begin
            wr.set       = (tail.mode == MODE_REGISTER) &&
                           (tail.match_found || tail.free_found);
            wr.drop      = (tail.mode == MODE_UNREGISTER) && tail.match_found;
            wr.clear_all = (tail.mode == MODE_CLEAR);
        end
    end

    assign out_load = (state_reg == ST_DRAIN) && (!out_valid_reg || rsp.ready);
    assign offset   = hold_reg.address - hold_reg.best_start;
    assign hit_now  = (hold_reg.mode == MODE_LOOKUP) && hold_reg.best_valid &&
                      (offset < {32'd0, hold_reg.best_len});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (tail.active)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RUN && tail.active)
        begin
            hold_reg <= tail;
        end
        if (out_load)
        begin
            hit_reg       <= hit_now;
            start_out_reg <= hit_now ? hold_reg.best_start : 64'd0;
            size_out_reg  <= hit_now ? hold_reg.best_len : 32'd0;
            id_out_reg    <= hit_now ? hold_reg.best_sym : 16'd0;
            full_reg      <= (hold_reg.mode == MODE_REGISTER) &&
                             !hold_reg.match_found && !hold_reg.free_found;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.hit         = hit_reg;
    assign rsp.found_start = start_out_reg;
    assign rsp.found_size  = size_out_reg;
    assign rsp.found_id    = id_out_reg;
    assign rsp.table_full  = full_reg;

endmodule
`default_nettype wire

@@ hdl/address_range_symbol_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// address_range_symbol_table
// Bounded table of code regions (start, size, symbol id) with register,
// unregister, clear and closest-start lookup, built as a chain of entry cells.
// ----------------------------------------------------------------------------
//
//  port  dir  item contents
//  ----  ---  -------------------------------------------------------------
//  req   in   mode, address, region_size, symbol_id
//  rsp   out  hit, found_start, found_size, found_id, table_full
//
//  One item at a time. An accepted item walks the cell chain one cell per
//  cycle; as it leaves the last cell the table update is applied and the
//  item is held, then the drain stage loads it into the result register.
//  req.ready is high only while no item is in the chain or waiting to load.
//  A result waiting on rsp does not block the next accept; a held result
//  stalls the following one in the drain stage until rsp is taken.
//  Reset empties the table (valid bits clear); entry data is not cleared.
//
module address_range_symbol_table
    import arsym_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    arsym_req_if.sink   req,
    arsym_rsp_if.source rsp
);

    // chain[0] is the injected item, chain[CAPACITY] leaves the last cell
    pkt_t chain [CAPACITY+1];
    wr_t  wr;

    arsym_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .inject (chain[0]),
        .tail   (chain[CAPACITY]),
        .wr     (wr)
    );

    // one cell per entry; the update bus reaches all cells at once
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        arsym_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (IDX_W'(i)),
            .pkt_in     (chain[i]),
            .wr         (wr),
            .pkt_out    (chain[i+1])
        );
    end

endmodule
`default_nettype wire
